[rtl/irp_pkg.sv]
// Shared types and constants for the IR pointer calibrate-and-map block.
package irp_pkg;

  localparam int CNT_W = 16;
  localparam int POS_W = 8;

  localparam logic OP_CAL = 1'b0;
  localparam logic OP_MAP = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  localparam logic [3:0] NOT_SEEN_SIZE = 4'd15;

  // paddr[2] selects the register word
  localparam logic CAL_SAMPLES_IDX = 1'b0;
  localparam logic [CNT_W-1:0] CAL_SAMPLES_RST = 16'd16;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[rtl/irp_div.sv]
// Restoring divider, one quotient bit per cycle.
module irp_div #(
  parameter int NW = 38,
  parameter int DW = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NW-1:0]     num,
  input  logic [DW-1:0]     den,
  output logic [NW-1:0]     quo,
  output irp_pkg::unit_stat_t stat
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW-1:0] r;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   r_sh;
  logic          ge;
  logic [DW:0]   r_sub;

  always_comb begin
    r_sh  = {r, q[NW-1]};
    ge    = (r_sh >= {1'b0, d});
    r_sub = r_sh - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= num;
        d    <= den;
        r    <= '0;
        cnt  <= CW'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        q   <= {q[NW-2:0], ge};
        r   <= ge ? r_sub[DW-1:0] : r_sh[DW-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo       = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[rtl/irp_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
module irp_sqrt #(
  parameter int RW = 38
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [RW-1:0]       rad,
  output logic [RW/2-1:0]     root,
  output irp_pkg::unit_stat_t stat
);

  localparam int HW = RW / 2;
  localparam int CW = $clog2(HW + 1);

  logic [RW-1:0]   v;
  logic [HW-1:0]   rt;
  logic [HW+1:0]   rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic            done;
  logic [HW+1:0]   rem_sh;
  logic [HW+1:0]   trial;
  logic            ge;

  always_comb begin
    rem_sh = {rem[HW-1:0], v[RW-1:RW-2]};
    trial  = {rt, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= rad;
        rt   <= '0;
        rem  <= '0;
        cnt  <= CW'(HW);
        busy <= 1'b1;
      end else if (busy) begin
        v   <= {v[RW-3:0], 2'b00};
        rem <= ge ? rem_sh - trial : rem_sh;
        rt  <= {rt[HW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root      = rt;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[rtl/irp_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle.
module irp_mul #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  output logic [2*W-1:0]      prod,
  output irp_pkg::unit_stat_t stat
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   ar;
  logic [2*W-1:0] p;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic           done;
  logic [W:0]     sum;

  always_comb begin
    sum = {1'b0, p[2*W-1:W]} + (p[0] ? {1'b0, ar} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ar   <= a;
        p    <= {{W{1'b0}}, b};
        cnt  <= CW'(W);
        busy <= 1'b1;
      end else if (busy) begin
        p   <= {sum, p[W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod      = p;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[rtl/ir_pointer_calibrate_and_map.sv]
// Top level: IR pointer corner calibration and two-dot position mapping.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+----------------------------------
//  s_axis    | in        | tvalid / tready       | tuser opcode, tdata dots
//  m_axis    | out       | tvalid / tready       | tuser status, tdata pos_x, pos_y
//  apb       | in        | psel/penable, pready=1| cal_samples at byte address 0
//
// One request at a time; s_axis_tready is high only while the sequencer is idle.
// Calibrate: accumulate one sample, then four divides when the target is reached.
// Map: six squares, a check, a root, a divide, a square, a root and the output.
// Result sits in an output register, so a stalled m_axis only holds the next
// request at its last step. Synchronous active-high reset clears control and calibration state.
module ir_pointer_calibrate_and_map #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // dot0_x, dot0_y, dot0_s, dot1_x, dot1_y, dot1_s, zero pad
  input  logic [((4*COORD_BITS+8+7)/8)*8-1:0] s_axis_tdata,
  // opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pos_x, pos_y
  output logic [2*irp_pkg::POS_W-1:0] m_axis_tdata,
  // status
  output logic        m_axis_tuser
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int SW    = C + irp_pkg::CNT_W;
  localparam int DSQW  = 2 * C + 1;
  localparam int NUMW  = 2 * C + 2;
  localparam int NUMSW = 2 * C + 3;
  localparam int DVW   = (SW > NUMW + 2 * F) ? SW : NUMW + 2 * F;
  localparam int DDW   = (irp_pkg::CNT_W > C + F + 2) ? irp_pkg::CNT_W : C + F + 2;
  localparam int RW    = 2 * C + 2 + 2 * F;
  localparam int HW    = RW / 2;
  localparam int XW    = (DVW > 32) ? 32 : DVW;
  localparam int MW    = 2 * XW;
  localparam int CMPW  = (DSQW + 2 * F > MW) ? DSQW + 2 * F : MW;
  localparam int PW    = irp_pkg::POS_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CAL_SUM, ST_CAL_DIV, ST_CAL_WAIT, ST_MAP_SQ, ST_MAP_CHK,
    ST_D_WAIT, ST_X_WAIT, ST_M_WAIT, ST_Y_WAIT, ST_RESULT
  } state_t;

  state_t state;

  logic [irp_pkg::CNT_W-1:0] cal_samples;
  logic                      calib_done;
  logic [irp_pkg::CNT_W-1:0] visible_count;
  logic [SW-1:0]             sum_x_first, sum_y_first, sum_x_second, sum_y_second;
  logic [C-1:0]              corner_x0, corner_y0, corner_x1, corner_y1;
  logic [1:0]                idx;
  logic [2:0]                k;

  logic [C-1:0]  x0, y0, x1, y1;
  logic [3:0]    s0, s1;

  logic [DSQW-1:0] d1sq, d2sq, dsq;
  logic [NUMW-1:0] num_u;
  logic [XW-1:0]   x_q;

  logic          res_status;
  logic [PW-1:0] res_x, res_y;

  logic             div_start, sq_start, mul_start;
  logic [DVW-1:0]   div_num;
  logic [DDW-1:0]   div_den;
  logic [RW-1:0]    sq_rad;
  logic [DVW-1:0]   div_quo;
  logic [HW-1:0]    sq_root;
  logic [MW-1:0]    mul_prod;
  irp_pkg::unit_stat_t div_stat, sq_stat, mul_stat;

  logic                      cfg_wr;
  logic                      vis;
  logic [irp_pkg::CNT_W-1:0] cnt_new;
  logic [irp_pkg::CNT_W-1:0] target;
  logic [SW-1:0]             sum_sel;
  logic [C-1:0]              sq_a, sq_b;
  logic [C:0]                diff, mag;
  logic [2*C-1:0]            sqr;
  logic signed [NUMSW-1:0]   num_s;
  logic [CMPW-1:0]           arg_c, sq_c;
  logic [XW-1:0]             xs;
  logic [HW-1:0]             ys;

  irp_div #(.NW(DVW), .DW(DDW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_quo), .stat(div_stat)
  );

  irp_sqrt #(.RW(RW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .rad(sq_rad),
    .root(sq_root), .stat(sq_stat)
  );

  irp_mul #(.W(XW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(x_q), .b(x_q),
    .prod(mul_prod), .stat(mul_stat)
  );

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign prdata        = (paddr[2] == irp_pkg::CAL_SAMPLES_IDX) ? 32'(cal_samples) : '0;
  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    vis = (x0 != '1) && (y0 != '1) && (s0 != irp_pkg::NOT_SEEN_SIZE) &&
          (x1 != '1) && (y1 != '1) && (s1 != irp_pkg::NOT_SEEN_SIZE);
    cnt_new = vis ? visible_count + 1'b1 : visible_count;
    target  = (cal_samples == '0) ? irp_pkg::CNT_W'(1) : cal_samples;
    case (idx)
      2'd0:    sum_sel = sum_x_first;
      2'd1:    sum_sel = sum_y_first;
      2'd2:    sum_sel = sum_x_second;
      default: sum_sel = sum_y_second;
    endcase
    case (k)
      3'd0:    begin sq_a = corner_x0; sq_b = x0; end
      3'd1:    begin sq_a = corner_y0; sq_b = y0; end
      3'd2:    begin sq_a = corner_x1; sq_b = x1; end
      3'd3:    begin sq_a = corner_y1; sq_b = y1; end
      3'd4:    begin sq_a = corner_x0; sq_b = corner_x1; end
      3'd5:    begin sq_a = corner_y0; sq_b = corner_y1; end
      default: begin sq_a = '0; sq_b = '0; end
    endcase
    diff  = {1'b0, sq_a} - {1'b0, sq_b};
    mag   = diff[C] ? -diff : diff;
    sqr   = mag[C-1:0] * mag[C-1:0];
    num_s = signed'(NUMSW'(d1sq)) - signed'(NUMSW'(d2sq)) + signed'(NUMSW'(dsq));
    arg_c = CMPW'(d1sq) << (2 * F);
    sq_c  = CMPW'(mul_prod);
    xs    = x_q >> F;
    ys    = sq_root >> F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cal_samples   <= irp_pkg::CAL_SAMPLES_RST;
      calib_done    <= 1'b0;
      visible_count <= '0;
      sum_x_first   <= '0;
      sum_y_first   <= '0;
      sum_x_second  <= '0;
      sum_y_second  <= '0;
      corner_x0     <= '0;
      corner_y0     <= '0;
      corner_x1     <= '0;
      corner_y1     <= '0;
      idx           <= '0;
      k             <= '0;
      m_axis_tvalid <= 1'b0;
      div_start     <= 1'b0;
      sq_start      <= 1'b0;
      mul_start     <= 1'b0;
    end else begin
      // start strobes last one cycle; no state issues a start right after one
      if (div_start) begin
        div_start <= 1'b0;
      end
      if (sq_start) begin
        sq_start <= 1'b0;
      end
      if (mul_start) begin
        mul_start <= 1'b0;
      end
      if (cfg_wr && paddr[2] == irp_pkg::CAL_SAMPLES_IDX) begin
        cal_samples <= pwdata[irp_pkg::CNT_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready && state != ST_RESULT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            x0 <= s_axis_tdata[C-1:0];
            y0 <= s_axis_tdata[2*C-1:C];
            s0 <= s_axis_tdata[2*C+3:2*C];
            x1 <= s_axis_tdata[3*C+3:2*C+4];
            y1 <= s_axis_tdata[4*C+3:3*C+4];
            s1 <= s_axis_tdata[4*C+7:4*C+4];
            res_status <= irp_pkg::ST_FAIL;
            res_x <= '0;
            res_y <= '0;
            k     <= '0;
            idx   <= '0;
            state <= (s_axis_tuser == irp_pkg::OP_CAL) ? ST_CAL_SUM : ST_MAP_SQ;
          end
        end
        ST_CAL_SUM: begin
          if (calib_done) begin
            state <= ST_RESULT;
          end else begin
            if (vis) begin
              sum_x_first   <= sum_x_first + SW'(x0);
              sum_y_first   <= sum_y_first + SW'(y0);
              sum_x_second  <= sum_x_second + SW'(x1);
              sum_y_second  <= sum_y_second + SW'(y1);
              visible_count <= cnt_new;
            end
            state <= (cnt_new >= target) ? ST_CAL_DIV : ST_RESULT;
          end
        end
        ST_CAL_DIV: begin
          div_num   <= DVW'(sum_sel);
          div_den   <= DDW'(visible_count);
          div_start <= 1'b1;
          state     <= ST_CAL_WAIT;
        end
        ST_CAL_WAIT: begin
          if (div_stat.done) begin
            case (idx)
              2'd0:    corner_x0 <= div_quo[C-1:0];
              2'd1:    corner_y0 <= div_quo[C-1:0];
              2'd2:    corner_x1 <= div_quo[C-1:0];
              default: corner_y1 <= div_quo[C-1:0];
            endcase
            if (idx == 2'd3) begin
              calib_done <= 1'b1;
              res_status <= irp_pkg::ST_OK;
              state      <= ST_RESULT;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_CAL_DIV;
            end
          end
        end
        ST_MAP_SQ: begin
          case (k)
            3'd0:    d1sq <= DSQW'(sqr);
            3'd1:    d1sq <= d1sq + DSQW'(sqr);
            3'd2:    d2sq <= DSQW'(sqr);
            3'd3:    d2sq <= d2sq + DSQW'(sqr);
            3'd4:    dsq  <= DSQW'(sqr);
            default: dsq  <= dsq + DSQW'(sqr);
          endcase
          k <= k + 1'b1;
          if (k == 3'd5) begin
            state <= ST_MAP_CHK;
          end
        end
        ST_MAP_CHK: begin
          if (dsq == '0 || num_s[NUMSW-1]) begin
            state <= ST_RESULT;
          end else begin
            num_u    <= num_s[NUMW-1:0];
            sq_rad   <= RW'(dsq) << (2 * F);
            sq_start <= 1'b1;
            state    <= ST_D_WAIT;
          end
        end
        ST_D_WAIT: begin
          if (sq_stat.done) begin
            if (sq_root == '0) begin
              state <= ST_RESULT;
            end else begin
              div_num   <= DVW'(num_u) << (2 * F);
              div_den   <= DDW'({sq_root, 1'b0});
              div_start <= 1'b1;
              state     <= ST_X_WAIT;
            end
          end
        end
        ST_X_WAIT: begin
          if (div_stat.done) begin
            if ((div_quo >> 32) != '0) begin
              state <= ST_RESULT;
            end else begin
              x_q       <= div_quo[XW-1:0];
              mul_start <= 1'b1;
              state     <= ST_M_WAIT;
            end
          end
        end
        ST_M_WAIT: begin
          if (mul_stat.done) begin
            if (arg_c < sq_c) begin
              state <= ST_RESULT;
            end else begin
              sq_rad   <= RW'(arg_c - sq_c);
              sq_start <= 1'b1;
              state    <= ST_Y_WAIT;
            end
          end
        end
        ST_Y_WAIT: begin
          if (sq_stat.done) begin
            res_status <= irp_pkg::ST_OK;
            res_x      <= (xs > XW'(255)) ? '1 : xs[PW-1:0];
            res_y      <= (ys > HW'(255)) ? '1 : ys[PW-1:0];
            state      <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_status;
            m_axis_tdata  <= {res_y, res_x};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(calib_done))
    else $error("calibration flag dropped");

  a_ok_needs_cal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == irp_pkg::ST_OK) |-> calib_done)
    else $error("success reported before calibration");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == irp_pkg::ST_FAIL) |-> (m_axis_tdata == '0))
    else $error("failed result carries a position");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");
`endif

endmodule
